@@ hdl/mfap_pkg.sv @@
// shared types, constants and codes of the max flow core
`default_nettype none
package mfap_pkg;

  localparam int MAX_VERTICES_DEF = 16;
  localparam int CAP_BITS_DEF     = 16;

  localparam int FLOW_W  = 20;
  localparam int VC_W    = 5;
  localparam int VTX_W   = 4;
  localparam int CAP_IN_W = 16;
  localparam logic [FLOW_W-1:0] FLOW_MAX = 20'hFFFFF;

  // register indexes on the configuration port
  localparam logic [1:0] REG_VERTEX_COUNT  = 2'd0;
  localparam logic [1:0] REG_SOURCE_VERTEX = 2'd1;
  localparam logic [1:0] REG_SINK_VERTEX   = 2'd2;

  typedef struct packed {
    logic [VC_W-1:0]  vertex_count;
    logic [VTX_W-1:0] source_vertex;
    logic [VTX_W-1:0] sink_vertex;
  } cfg_t;

  typedef enum logic [1:0] {
    ALU_SUB,
    ALU_ADD,
    ALU_MIN,
    ALU_ACC
  } alu_op_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_INIT,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_POP_GET,
    ST_P1_PAR,
    ST_P1_RES,
    ST_P1_MIN,
    ST_P2_PAR,
    ST_P2_FWD,
    ST_P2_FWR,
    ST_P2_REV,
    ST_ACC,
    ST_RESULT
  } state_t;

endpackage
`default_nettype wire

@@ hdl/mfap_ram.sv @@
// generic single write port, single read port ram with registered read
`default_nettype none
module mfap_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

@@ hdl/mfap_alu.sv @@
// shared arithmetic unit: subtract, add, minimum, saturating accumulate
`default_nettype none
module mfap_alu #(
  parameter int AW = 21
) (
  input  mfap_pkg::alu_op_t op,
  input  wire logic [AW-1:0] a,
  input  wire logic [AW-1:0] b,
  output logic      [AW-1:0] y
);
  import mfap_pkg::*;

  logic [AW-1:0] sum;
  assign sum = a + b;

  always_comb begin
    unique case (op)
      ALU_SUB: y = a - b;
      ALU_ADD: y = sum;
      ALU_MIN: y = (b < a) ? b : a;
      ALU_ACC: y = (sum > AW'(FLOW_MAX)) ? AW'(FLOW_MAX) : sum;
    endcase
  end

endmodule
`default_nettype wire

@@ hdl/mfap_cfg.sv @@
// apb-style configuration registers
`default_nettype none
module mfap_cfg (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready,
  output mfap_pkg::cfg_t   cfg
);
  import mfap_pkg::*;

  cfg_t cfg_r;
  logic wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en = cfg_psel && cfg_penable && cfg_pwrite;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.vertex_count  <= VC_W'(16);
      cfg_r.source_vertex <= VTX_W'(0);
      cfg_r.sink_vertex   <= VTX_W'(1);
    end else if (wr_en) begin
      priority case (cfg_paddr[3:2])
        REG_VERTEX_COUNT:  cfg_r.vertex_count  <= cfg_pwdata[VC_W-1:0];
        REG_SOURCE_VERTEX: cfg_r.source_vertex <= cfg_pwdata[VTX_W-1:0];
        REG_SINK_VERTEX:   cfg_r.sink_vertex   <= cfg_pwdata[VTX_W-1:0];
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    priority case (cfg_paddr[3:2])
      REG_VERTEX_COUNT:  cfg_prdata = 32'(cfg_r.vertex_count);
      REG_SOURCE_VERTEX: cfg_prdata = 32'(cfg_r.source_vertex);
      REG_SINK_VERTEX:   cfg_prdata = 32'(cfg_r.sink_vertex);
      default:           cfg_prdata = 32'd0;
    endcase
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

@@ hdl/mfap_seq.sv @@
// sequencer: matrix load, depth-first search, path augment, result and clear sweep
`default_nettype none
module mfap_seq #(
  parameter int MAX_VERTICES = mfap_pkg::MAX_VERTICES_DEF,
  parameter int CAP_BITS     = mfap_pkg::CAP_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  mfap_pkg::cfg_t                     cfg,
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [mfap_pkg::VTX_W-1:0]    in_from,
  input  wire logic [mfap_pkg::VTX_W-1:0]    in_to,
  input  wire logic [mfap_pkg::CAP_IN_W-1:0] in_cap,
  input  wire logic                          in_last,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output logic      [mfap_pkg::FLOW_W-1:0]   out_flow,
  output logic                               out_same
);
  import mfap_pkg::*;

  localparam int VW   = $clog2(MAX_VERTICES);
  localparam int CW0  = $clog2(MAX_VERTICES + 1);
  localparam int CW   = (CW0 > VC_W) ? CW0 : VC_W;
  localparam int RW   = CAP_BITS + 1;
  localparam int AW   = ((RW > FLOW_W) ? RW : FLOW_W) + 1;
  localparam int WIDE = (CAP_IN_W > RW) ? CAP_IN_W : RW;
  localparam int RDEP = 2 ** (2 * VW);

  state_t state_r, state_nxt;
  logic [CW-1:0]     depth_r, depth_nxt;
  logic [CW-1:0]     v_r, v_nxt;
  logic [VW-1:0]     u_r, u_nxt;
  logic [VW-1:0]     cur_r, cur_nxt;
  logic [VW-1:0]     p_r, p_nxt;
  logic [RW-1:0]     pf_r, pf_nxt;
  logic [FLOW_W-1:0] total_r, total_nxt;
  logic              same_r, same_nxt;
  logic [MAX_VERTICES-1:0] vis_r, vis_nxt;
  logic [2*VW-1:0]   clr_r, clr_nxt;

  // memory ports
  logic            res_we;
  logic [2*VW-1:0] res_waddr, res_raddr;
  logic [RW-1:0]   res_wdata, res_rd;
  logic            stk_we;
  logic [VW-1:0]   stk_waddr, stk_wdata, stk_raddr, stk_rd;
  logic            par_we;
  logic [VW-1:0]   par_waddr, par_wdata, par_raddr, par_rd;

  // shared unit
  alu_op_t         alu_op;
  logic [AW-1:0]   alu_a, alu_b, alu_y;

  // configuration views
  logic [CW-1:0]   vc_w, nv, s_w, t_w, from_w, to_w, dm2;
  logic [VW-1:0]   s_v, t_v, v_v;
  logic            accept, in_ok, ends_ok, v_end, hit;
  logic [WIDE-1:0] cap_wide, cap_lim;
  logic [RW-1:0]   cap_sat;

  assign vc_w   = CW'(cfg.vertex_count);
  assign nv     = (vc_w > CW'(MAX_VERTICES)) ? CW'(MAX_VERTICES) : vc_w;
  assign s_w    = CW'(cfg.source_vertex);
  assign t_w    = CW'(cfg.sink_vertex);
  assign s_v    = s_w[VW-1:0];
  assign t_v    = t_w[VW-1:0];
  assign from_w = CW'(in_from);
  assign to_w   = CW'(in_to);
  assign in_ok  = (from_w < nv) && (to_w < nv);
  assign ends_ok = (s_w < nv) && (t_w < nv);
  assign accept = in_valid && in_ready;
  assign v_v    = v_r[VW-1:0];
  assign v_end  = (v_r == nv);
  assign hit    = !vis_r[v_v] && (res_rd != '0);
  assign dm2    = depth_r - CW'(2);

  // capacity saturates to the largest CAP_BITS-bit value
  assign cap_wide = WIDE'(in_cap);
  assign cap_lim  = {{(WIDE-CAP_BITS){1'b0}}, {CAP_BITS{1'b1}}};
  assign cap_sat  = RW'((cap_wide > cap_lim) ? cap_lim : cap_wide);

  mfap_ram #(.WIDTH(RW), .DEPTH(RDEP)) u_res (
    .clk(clk), .we(res_we), .waddr(res_waddr), .wdata(res_wdata),
    .raddr(res_raddr), .rdata(res_rd)
  );

  mfap_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_stk (
    .clk(clk), .we(stk_we), .waddr(stk_waddr), .wdata(stk_wdata),
    .raddr(stk_raddr), .rdata(stk_rd)
  );

  mfap_ram #(.WIDTH(VW), .DEPTH(MAX_VERTICES)) u_par (
    .clk(clk), .we(par_we), .waddr(par_waddr), .wdata(par_wdata),
    .raddr(par_raddr), .rdata(par_rd)
  );

  mfap_alu #(.AW(AW)) u_alu (
    .op(alu_op), .a(alu_a), .b(alu_b), .y(alu_y)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (clr_r == '1) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept && in_last) begin
          if (cfg.source_vertex == cfg.sink_vertex) state_nxt = ST_RESULT;
          else if (ends_ok) state_nxt = ST_INIT;
          else state_nxt = ST_RESULT;
        end
      end
      ST_INIT:    state_nxt = ST_SCAN_RD;
      ST_SCAN_RD: begin
        if (!v_end) state_nxt = ST_SCAN_CHK;
        else if (depth_r == CW'(1)) state_nxt = ST_RESULT;
        else state_nxt = ST_POP_GET;
      end
      ST_SCAN_CHK: begin
        if (hit && (v_v == t_v)) state_nxt = ST_P1_PAR;
        else state_nxt = ST_SCAN_RD;
      end
      ST_POP_GET: state_nxt = ST_SCAN_RD;
      ST_P1_PAR:  state_nxt = ST_P1_RES;
      ST_P1_RES:  state_nxt = ST_P1_MIN;
      ST_P1_MIN:  state_nxt = (p_r == s_v) ? ST_P2_PAR : ST_P1_PAR;
      ST_P2_PAR:  state_nxt = ST_P2_FWD;
      ST_P2_FWD:  state_nxt = ST_P2_FWR;
      ST_P2_FWR:  state_nxt = ST_P2_REV;
      ST_P2_REV:  state_nxt = (p_r == s_v) ? ST_ACC : ST_P2_PAR;
      ST_ACC:     state_nxt = ST_INIT;
      ST_RESULT: begin
        if (out_ready) state_nxt = ST_CLEAR;
      end
      default:    state_nxt = ST_CLEAR;
    endcase
  end

  // datapath controls and register updates
  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    depth_nxt = depth_r;
    v_nxt     = v_r;
    u_nxt     = u_r;
    cur_nxt   = cur_r;
    p_nxt     = p_r;
    pf_nxt    = pf_r;
    total_nxt = total_r;
    same_nxt  = same_r;
    vis_nxt   = vis_r;
    clr_nxt   = clr_r;
    res_we    = 1'b0;
    res_waddr = {u_r, v_v};
    res_wdata = '0;
    res_raddr = {u_r, v_v};
    stk_we    = 1'b0;
    stk_waddr = depth_r[VW-1:0];
    stk_wdata = v_v;
    stk_raddr = dm2[VW-1:0];
    par_we    = 1'b0;
    par_waddr = v_v;
    par_wdata = u_r;
    par_raddr = cur_r;
    alu_op    = ALU_MIN;
    alu_a     = AW'(pf_r);
    alu_b     = AW'(res_rd);
    unique case (state_r)
      // zero sweep of the residual store
      ST_CLEAR: begin
        res_we    = 1'b1;
        res_waddr = clr_r;
        clr_nxt   = clr_r + 1'b1;
      end
      // matrix load, one entry a beat
      ST_IDLE: begin
        in_ready  = 1'b1;
        res_waddr = {from_w[VW-1:0], to_w[VW-1:0]};
        res_wdata = cap_sat;
        if (accept) begin
          res_we = in_ok;
          if (in_last) begin
            total_nxt = '0;
            same_nxt  = (cfg.source_vertex == cfg.sink_vertex);
          end
        end
      end
      // fresh search from the source
      ST_INIT: begin
        vis_nxt   = MAX_VERTICES'(1) << s_v;
        stk_we    = 1'b1;
        stk_waddr = '0;
        stk_wdata = s_v;
        depth_nxt = CW'(1);
        u_nxt     = s_v;
        v_nxt     = '0;
      end
      // read residual of the next candidate, or pop when the row is done
      ST_SCAN_RD: begin
        if (v_end) depth_nxt = depth_r - CW'(1);
      end
      ST_SCAN_CHK: begin
        if (hit) begin
          par_we      = 1'b1;
          vis_nxt[v_v] = 1'b1;
          if (v_v == t_v) begin
            cur_nxt = t_v;
            pf_nxt  = '1;
          end else begin
            stk_we    = 1'b1;
            depth_nxt = depth_r + CW'(1);
            u_nxt     = v_v;
            v_nxt     = '0;
          end
        end else begin
          v_nxt = v_r + CW'(1);
        end
      end
      ST_POP_GET: begin
        u_nxt = stk_rd;
        v_nxt = '0;
      end
      // bottleneck walk from sink back to source
      ST_P1_PAR: ;
      ST_P1_RES: begin
        p_nxt     = par_rd;
        res_raddr = {par_rd, cur_r};
      end
      ST_P1_MIN: begin
        pf_nxt  = RW'(alu_y);
        cur_nxt = (p_r == s_v) ? t_v : p_r;
      end
      // augment walk: forward minus, reverse plus
      ST_P2_PAR: ;
      ST_P2_FWD: begin
        p_nxt     = par_rd;
        res_raddr = {par_rd, cur_r};
      end
      ST_P2_FWR: begin
        alu_op    = ALU_SUB;
        alu_a     = AW'(res_rd);
        alu_b     = AW'(pf_r);
        res_we    = 1'b1;
        res_waddr = {p_r, cur_r};
        res_wdata = RW'(alu_y);
        res_raddr = {cur_r, p_r};
      end
      ST_P2_REV: begin
        alu_op    = ALU_ADD;
        alu_a     = AW'(res_rd);
        alu_b     = AW'(pf_r);
        res_we    = 1'b1;
        res_waddr = {cur_r, p_r};
        res_wdata = RW'(alu_y);
        cur_nxt   = p_r;
      end
      ST_ACC: begin
        alu_op    = ALU_ACC;
        alu_a     = AW'(total_r);
        alu_b     = AW'(pf_r);
        total_nxt = FLOW_W'(alu_y);
      end
      ST_RESULT: begin
        out_valid = 1'b1;
        clr_nxt   = '0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    depth_r <= depth_nxt;
    v_r     <= v_nxt;
    u_r     <= u_nxt;
    cur_r   <= cur_nxt;
    p_r     <= p_nxt;
    pf_r    <= pf_nxt;
    total_r <= total_nxt;
    same_r  <= same_nxt;
    vis_r   <= vis_nxt;
  end

  assign out_flow = total_r;
  assign out_same = same_r;

endmodule
`default_nettype wire

@@ hdl/max_flow_augmenting_path_core.sv @@
// top level of the augmenting path max flow core
// Usage: capacity matrix entries arrive on the in_ stream, one beat per cycle
// while the core is idle. An entry whose row or column is at or above the
// configured vertex count is dropped. The beat with in_tlast high is stored,
// then the core drops in_tready and runs depth-first searches for augmenting
// paths from source to sink, or goes straight to the result if source equals
// sink or either is out of range. A candidate edge takes SCAN_RD, SCAN_CHK, a
// pop SCAN_RD, POP_GET; a path walks P1_PAR, P1_RES, P1_MIN per edge for the
// bottleneck, then P2_PAR, P2_FWD, P2_FWR, P2_REV per edge to augment, then
// ACC, INIT. The result beat (total flow in out_tdata, endpoint flag in
// out_tuser) holds on the out_ stream until out_tready; then the residual
// store is swept to zero, one entry a cycle, 2^(2*clog2(MAX_VERTICES))
// entries (256 by default), as after reset before the first in_tready. The
// user configures via the cfg_ port while the core is idle (not enforced).
`default_nettype none
module max_flow_augmenting_path_core #(
  parameter int MAX_VERTICES = mfap_pkg::MAX_VERTICES_DEF,
  parameter int CAP_BITS     = mfap_pkg::CAP_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic      [31:0] cfg_prdata,
  output logic             cfg_pready,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // from_vertex [3:0], to_vertex [7:4], capacity [23:8]
  input  wire logic [23:0] in_tdata,
  // last_entry
  input  wire logic        in_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // flow total [19:0], zero pad [23:20]
  output logic      [23:0] out_tdata,
  // same_endpoints
  output logic             out_tuser
);
  import mfap_pkg::*;

  cfg_t              cfg;
  logic [FLOW_W-1:0] flow;

  mfap_cfg u_cfg (
    .clk(clk), .rst_n(rst_n),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata),
    .cfg_prdata(cfg_prdata), .cfg_pready(cfg_pready),
    .cfg(cfg)
  );

  mfap_seq #(.MAX_VERTICES(MAX_VERTICES), .CAP_BITS(CAP_BITS)) u_seq (
    .clk(clk), .rst_n(rst_n), .cfg(cfg),
    .in_valid(in_tvalid), .in_ready(in_tready),
    .in_from(in_tdata[3:0]), .in_to(in_tdata[7:4]), .in_cap(in_tdata[23:8]),
    .in_last(in_tlast),
    .out_valid(out_tvalid), .out_ready(out_tready),
    .out_flow(flow), .out_same(out_tuser)
  );

  // result beat packing
  assign out_tdata = {4'd0, flow};

endmodule
`default_nettype wire
